FILE: rtl/wstd_pkg.sv
// Shared types and codes for the work-stealing task dispatcher.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none
package wstd_pkg;

    // Request kinds carried in the input tuser.
    localparam logic [1:0] REQ_SUBMIT   = 2'd0;
    localparam logic [1:0] REQ_FETCH    = 2'd1;
    localparam logic [1:0] REQ_COMPLETE = 2'd2;
    localparam logic [1:0] REQ_NOP      = 2'd3;

    // Preferred worker classes.
    localparam logic [1:0] CLS_ANY  = 2'd0;
    localparam logic [1:0] CLS_PERF = 2'd1;
    localparam logic [1:0] CLS_EFF  = 2'd2;

    // Result codes carried in the output tuser.
    localparam logic [3:0] RES_QUEUED_LOCAL  = 4'd0;
    localparam logic [3:0] RES_QUEUED_GLOBAL = 4'd1;
    localparam logic [3:0] RES_REJECTED      = 4'd2;
    localparam logic [3:0] RES_GOT_LOCAL     = 4'd3;
    localparam logic [3:0] RES_GOT_GLOBAL    = 4'd4;
    localparam logic [3:0] RES_STOLEN        = 4'd5;
    localparam logic [3:0] RES_NONE          = 4'd6;
    localparam logic [3:0] RES_COMPLETED     = 4'd7;
    localparam logic [3:0] RES_BAD_WORKER    = 4'd8;

    // Configuration register indexes.
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 5;
    localparam logic [CFG_AW-1:0] CFG_WORKER_COUNT = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_PERF_COUNT   = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_STEAL_EN     = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;
        logic       idx_clr;
        logic       idx_inc;
        logic       idx_set_w;
        logic       idx_set_tgt;
        logic       best_upd;
        logic       push_local;
        logic       push_global;
        logic       pop_local;
        logic       pop_global;
        logic       done_inc;
        logic       take_task;
        logic       set_code;
        logic [3:0] code;
        logic       emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] req;
        logic       w_valid;
        logic       idx_in;
        logic       idx_is_w;
        logic       cand;
        logic       found;
        logic       lfull;
        logic       lempty;
        logic       gfull;
        logic       gempty;
        logic       steal_en;
        logic       out_busy;
    } t_stat;

endpackage
`default_nettype wire

FILE: rtl/wstd_ctrl.sv
// Controller state machine of the dispatcher: sequences scans, pushes and pops.
// Depends on wstd_pkg for the command and status structs and result codes.
`default_nettype none
module wstd_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_tvalid,
    output logic                o_s_tready,
    input  wire wstd_pkg::t_stat i_stat,
    output wstd_pkg::t_cmd      o_cmd
);
    import wstd_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_TGT   = 4'd3;
    localparam logic [3:0] S_PUSH  = 4'd4;
    localparam logic [3:0] S_CMPL  = 4'd5;
    localparam logic [3:0] S_LCHK  = 4'd6;
    localparam logic [3:0] S_STEAL = 4'd7;
    localparam logic [3:0] S_RD    = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_s_tready = (r_state == S_IDLE);

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DEC;
                end
            end
            S_DEC: begin
                if (i_stat.req == REQ_NOP) begin
                    n_state = S_IDLE;
                end else if (i_stat.req == REQ_SUBMIT) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_SCAN;
                end else if (!i_stat.w_valid) begin
                    o_cmd.set_code = 1'b1;
                    o_cmd.code     = RES_BAD_WORKER;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.idx_set_w = 1'b1;
                    n_state = (i_stat.req == REQ_COMPLETE) ? S_CMPL : S_LCHK;
                end
            end
            S_SCAN: begin
                if (!i_stat.idx_in) begin
                    o_cmd.idx_set_tgt = 1'b1;
                    n_state           = S_TGT;
                end else begin
                    o_cmd.best_upd = i_stat.cand;
                    o_cmd.idx_inc  = 1'b1;
                end
            end
            S_TGT: begin
                n_state = S_PUSH;
            end
            S_PUSH: begin
                o_cmd.set_code = 1'b1;
                n_state        = S_DONE;
                if (i_stat.found && !i_stat.lfull) begin
                    o_cmd.push_local = 1'b1;
                    o_cmd.code       = RES_QUEUED_LOCAL;
                end else if (!i_stat.gfull) begin
                    o_cmd.push_global = 1'b1;
                    o_cmd.code        = RES_QUEUED_GLOBAL;
                end else begin
                    o_cmd.code = RES_REJECTED;
                end
            end
            S_CMPL: begin
                o_cmd.done_inc = 1'b1;
                o_cmd.set_code = 1'b1;
                o_cmd.code     = RES_COMPLETED;
                n_state        = S_DONE;
            end
            S_LCHK: begin
                if (!i_stat.lempty) begin
                    o_cmd.pop_local = 1'b1;
                    o_cmd.set_code  = 1'b1;
                    o_cmd.code      = RES_GOT_LOCAL;
                    n_state         = S_RD;
                end else if (!i_stat.gempty) begin
                    o_cmd.pop_global = 1'b1;
                    o_cmd.set_code   = 1'b1;
                    o_cmd.code       = RES_GOT_GLOBAL;
                    n_state          = S_RD;
                end else if (i_stat.steal_en) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_STEAL;
                end else begin
                    o_cmd.set_code = 1'b1;
                    o_cmd.code     = RES_NONE;
                    n_state        = S_DONE;
                end
            end
            S_STEAL: begin
                if (!i_stat.idx_in) begin
                    o_cmd.set_code = 1'b1;
                    o_cmd.code     = RES_NONE;
                    n_state        = S_DONE;
                end else if (!i_stat.idx_is_w && !i_stat.lempty) begin
                    o_cmd.pop_local = 1'b1;
                    o_cmd.set_code  = 1'b1;
                    o_cmd.code      = RES_STOLEN;
                    n_state         = S_RD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_RD: begin
                o_cmd.take_task = 1'b1;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/wstd_dp.sv
// Datapath of the dispatcher: configuration, per-worker queue state, tag stores
// and the output register. Depends on wstd_pkg for the command and status structs.
`default_nettype none
module wstd_dp #(
    parameter int NUM_WORKERS = 16,
    parameter int RING_DEPTH  = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [wstd_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  wire logic [wstd_pkg::CFG_DW-1:0]  i_cfg_wdata,
    input  wire logic [1:0]                   i_req,
    input  wire logic [3:0]                   i_worker,
    input  wire logic [31:0]                  i_tag,
    input  wire logic [1:0]                   i_pref,
    input  wire wstd_pkg::t_cmd               i_cmd,
    output wstd_pkg::t_stat                   o_stat,
    output logic                              o_m_tvalid,
    input  wire logic                         i_m_tready,
    output logic [3:0]                        o_code,
    output logic [3:0]                        o_chosen,
    output logic [31:0]                       o_task
);
    import wstd_pkg::*;

    localparam int WB  = $clog2(NUM_WORKERS);
    localparam int CW  = $clog2(NUM_WORKERS + 1);
    localparam int RB  = $clog2(RING_DEPTH);
    localparam int XW  = (CW > 5) ? CW : 5;
    localparam int LAW = $clog2(NUM_WORKERS * RING_DEPTH);

    function automatic logic [RB-1:0] f_next(input logic [RB-1:0] p);
        f_next = (p == RB'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Configuration registers.
    logic [4:0] r_wc;
    logic [4:0] r_perf;
    logic       r_steal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc    <= 5'd16;
            r_perf  <= 5'd10;
            r_steal <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_WORKER_COUNT: r_wc    <= i_cfg_wdata;
                CFG_PERF_COUNT:   r_perf  <= i_cfg_wdata;
                CFG_STEAL_EN:     r_steal <= i_cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    // Captured request.
    logic [1:0]  r_req;
    logic [3:0]  r_w;
    logic [31:0] r_tag;
    logic [1:0]  r_pref;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req  <= i_req;
            r_w    <= i_worker;
            r_tag  <= i_tag;
            r_pref <= i_pref;
        end
    end

    // Scan index, best candidate and target.
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_tgt;
    logic [32:0]   r_best;
    logic          r_found;
    logic [WB-1:0] idx_w;
    logic [CW-1:0] act_cnt;

    assign idx_w   = r_idx[WB-1:0];
    assign act_cnt = (XW'(r_wc) >= XW'(NUM_WORKERS)) ? CW'(NUM_WORKERS) : CW'(r_wc);

    // Per-worker queue state, read at the scan index only.
    logic [RB-1:0] r_head [NUM_WORKERS];
    logic [RB-1:0] r_tail [NUM_WORKERS];
    logic [RB-1:0] r_fill [NUM_WORKERS];
    logic [31:0]   r_done [NUM_WORKERS];
    logic [RB-1:0] r_ghead;
    logic [RB-1:0] r_gtail;

    logic [32:0]   load;
    logic [1:0]    cls;
    logic          cls_ok;

    assign load   = {1'b0, r_done[idx_w]} + 33'(r_fill[idx_w]);
    assign cls    = (XW'(r_idx) < XW'(r_perf)) ? CLS_PERF : CLS_EFF;
    assign cls_ok = (r_pref == CLS_ANY) || (r_pref == cls);

    always_ff @(posedge i_clk) begin
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end else if (i_cmd.idx_set_w) begin
            r_idx <= CW'(r_w);
        end else if (i_cmd.idx_set_tgt) begin
            r_idx <= r_tgt;
        end
        if (i_cmd.best_upd) begin
            r_best <= load;
            r_tgt  <= r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.capture) begin
            r_found <= 1'b0;
        end else if (i_cmd.best_upd) begin
            r_found <= 1'b1;
        end
    end

    // Queue pointers, fill counts and completion counts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_WORKERS; k++) begin
                r_head[k] <= '0;
                r_tail[k] <= '0;
                r_fill[k] <= '0;
                r_done[k] <= '0;
            end
            r_ghead <= '0;
            r_gtail <= '0;
        end else begin
            if (i_cmd.push_local) begin
                r_tail[idx_w] <= f_next(r_tail[idx_w]);
                r_fill[idx_w] <= r_fill[idx_w] + 1'b1;
            end
            if (i_cmd.pop_local) begin
                r_head[idx_w] <= f_next(r_head[idx_w]);
                r_fill[idx_w] <= r_fill[idx_w] - 1'b1;
            end
            if (i_cmd.done_inc && (r_done[idx_w] != 32'hFFFF_FFFF)) begin
                r_done[idx_w] <= r_done[idx_w] + 32'd1;
            end
            if (i_cmd.push_global) begin
                r_gtail <= f_next(r_gtail);
            end
            if (i_cmd.pop_global) begin
                r_ghead <= f_next(r_ghead);
            end
        end
    end

    // Tag stores with registered reads.
    logic [31:0]    r_lmem [NUM_WORKERS * RING_DEPTH];
    logic [31:0]    r_gmem [RING_DEPTH];
    logic [31:0]    r_lrd;
    logic [31:0]    r_grd;
    logic           r_src_g;
    logic [LAW-1:0] lbase;

    assign lbase = LAW'(idx_w) * LAW'(RING_DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_local) begin
            r_lmem[lbase + LAW'(r_tail[idx_w])] <= r_tag;
        end
        if (i_cmd.pop_local) begin
            r_lrd <= r_lmem[lbase + LAW'(r_head[idx_w])];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_global) begin
            r_gmem[r_gtail] <= r_tag;
        end
        if (i_cmd.pop_global) begin
            r_grd <= r_gmem[r_ghead];
        end
    end

    // Result holding registers.
    logic [3:0]  r_code;
    logic [31:0] r_task;

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop_local) begin
            r_src_g <= 1'b0;
        end else if (i_cmd.pop_global) begin
            r_src_g <= 1'b1;
        end
        if (i_cmd.set_code) begin
            r_code <= i_cmd.code;
        end
        if (i_cmd.capture) begin
            r_task <= '0;
        end else if (i_cmd.take_task) begin
            r_task <= r_src_g ? r_grd : r_lrd;
        end
    end

    // Output register; the chosen worker is the scan index for codes that name one.
    logic idx_named;

    assign idx_named = (r_code == RES_QUEUED_LOCAL) || (r_code == RES_GOT_LOCAL) ||
                       (r_code == RES_STOLEN) || (r_code == RES_COMPLETED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_tvalid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            o_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_code   <= r_code;
            o_chosen <= idx_named ? 4'(r_idx) : 4'd0;
            o_task   <= r_task;
        end
    end

    // Status toward the controller.
    always_comb begin
        o_stat          = '0;
        o_stat.req      = r_req;
        o_stat.w_valid  = XW'(r_w) < XW'(act_cnt);
        o_stat.idx_in   = r_idx < act_cnt;
        o_stat.idx_is_w = XW'(r_idx) == XW'(r_w);
        o_stat.cand     = cls_ok && (!r_found || (load < r_best));
        o_stat.found    = r_found;
        o_stat.lfull    = r_fill[idx_w] == RB'(RING_DEPTH - 1);
        o_stat.lempty   = r_fill[idx_w] == '0;
        o_stat.gfull    = f_next(r_gtail) == r_ghead;
        o_stat.gempty   = r_ghead == r_gtail;
        o_stat.steal_en = r_steal;
        o_stat.out_busy = o_m_tvalid && !i_m_tready;
    end

endmodule
`default_nettype wire

FILE: rtl/work_stealing_task_dispatcher.sv
// Top level of the work-stealing task dispatcher: joins controller and datapath.
// Depends on wstd_pkg, wstd_ctrl and wstd_dp.
//
// Channel   Direction  Ports                        Moves
// s         in         i_s_tvalid/o_s_tready        request (submit, fetch, complete, nop)
// m         out        o_m_tvalid/i_m_tready        result code, chosen worker, task
// cfg       in         i_cfg_we/i_cfg_addr/wdata    register writes, no read-back
//
// One request is in work at a time. A submit scans every active worker. A fetch pops
// its own or the global queue; if both are empty and stealing is enabled, it scans
// the other workers until one has a task to steal. The scan visits one worker per
// cycle. A pop goes through the registered tag store read before the task is taken.
// The result waits in the output register while the next request is taken. Reset
// clears pointers, fill and completion counts at once; the tag stores are not cleared.
`default_nettype none
module work_stealing_task_dispatcher #(
    parameter int NUM_WORKERS = 16,
    parameter int RING_DEPTH  = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_s_tvalid,
    output logic                              o_s_tready,
    input  wire logic [39:0]                  i_s_tdata,   // worker[3:0], task_tag, preferred_class, pad
    input  wire logic [1:0]                   i_s_tuser,   // req_type
    output logic                              o_m_tvalid,
    input  wire logic                         i_m_tready,
    output logic [39:0]                       o_m_tdata,   // chosen_worker[3:0], task_out, pad
    output logic [3:0]                        o_m_tuser,   // result_code
    input  wire logic                         i_cfg_we,
    input  wire logic [wstd_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  wire logic [wstd_pkg::CFG_DW-1:0]  i_cfg_wdata
);
    import wstd_pkg::*;

    t_cmd        cmd;
    t_stat       stat;
    logic [3:0]  chosen;
    logic [31:0] task_out;

    wstd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    wstd_dp #(
        .NUM_WORKERS (NUM_WORKERS),
        .RING_DEPTH  (RING_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_s_tuser),
        .i_worker    (i_s_tdata[3:0]),
        .i_tag       (i_s_tdata[35:4]),
        .i_pref      (i_s_tdata[37:36]),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_code      (o_m_tuser),
        .o_chosen    (chosen),
        .o_task      (task_out)
    );

    assign o_m_tdata = {4'd0, task_out, chosen};

`ifndef SYNTHESIS
    // A taken request keeps the input closed on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input open right after a request was taken");

    // A new result never overwrites one that is still waiting.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!o_m_tvalid || i_m_tready))
        else $error("result emitted over a pending result");

    // A tag goes to one queue only.
    a_one_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.push_local && cmd.push_global))
        else $error("tag pushed to local and global queue together");

    // Delivered codes stay within the defined set.
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser <= RES_BAD_WORKER))
        else $error("undefined result code");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_work_stealing_task_dispatcher.sv
// Self-checking testbench for the work-stealing task dispatcher.
// Depends on wstd_pkg and work_stealing_task_dispatcher; a scoreboard class models the queues.
`default_nettype none
module tb_work_stealing_task_dispatcher;
    import wstd_pkg::*;

    localparam int NW = 16;
    localparam int RD = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    // Expected result of one transaction.
    typedef struct packed {
        logic [3:0]  code;
        logic [3:0]  chosen;
        logic [31:0] task_out;
    } t_result;

    // Dispatcher state mirror plus the queue of expected results.
    class dispatch_scoreboard;
        logic [31:0] lring [NW][RD];
        int          lhead [NW];
        int          ltail [NW];
        int          lfill [NW];
        logic [31:0] gring [RD];
        int          ghead;
        int          gtail;
        logic [31:0] done_cnt [NW];
        int          n_workers;
        int          n_perf;
        bit          steal_on;
        t_result     pending [$];
        int          mismatches;
        int          checked;

        function void clear();
            for (int i = 0; i < NW; i++) begin
                lhead[i] = 0;
                ltail[i] = 0;
                lfill[i] = 0;
                done_cnt[i] = '0;
            end
            ghead = 0;
            gtail = 0;
            n_workers = 16;
            n_perf = 10;
            steal_on = 1;
            mismatches = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [4:0] val);
            if (idx == CFG_WORKER_COUNT) n_workers = val;
            else if (idx == CFG_PERF_COUNT) n_perf = val;
            else if (idx == CFG_STEAL_EN) steal_on = val[0];
        endfunction

        // The tag is left as it was when the ring is empty.
        function bit pop_local(int w, inout logic [31:0] tg);
            if (lfill[w] == 0) return 0;
            tg = lring[w][lhead[w]];
            lhead[w] = (lhead[w] + 1) % RD;
            lfill[w]--;
            return 1;
        endfunction

        // Works out the result of an accepted request and queues it.
        function void note_request(logic [1:0] req, logic [3:0] w, logic [31:0] tg,
                                   logic [1:0] pref);
            t_result r;
            int n;
            longint best;
            longint load;
            int tgt;
            bit found;
            int cls;
            n = (n_workers > NW) ? NW : n_workers;
            r = '0;
            if (req == REQ_NOP) return;
            if (req == REQ_SUBMIT) begin
                best = -1;
                found = 0;
                tgt = 0;
                for (int i = 0; i < n; i++) begin
                    cls = (i < n_perf) ? CLS_PERF : CLS_EFF;
                    if (pref != CLS_ANY && cls != pref) continue;
                    load = longint'(done_cnt[i]) + lfill[i];
                    if (!found || load < best) begin
                        best = load;
                        tgt = i;
                        found = 1;
                    end
                end
                if (found && lfill[tgt] < RD - 1) begin
                    lring[tgt][ltail[tgt]] = tg;
                    ltail[tgt] = (ltail[tgt] + 1) % RD;
                    lfill[tgt]++;
                    r.code = RES_QUEUED_LOCAL;
                    r.chosen = tgt[3:0];
                end else if ((gtail + 1) % RD != ghead) begin
                    gring[gtail] = tg;
                    gtail = (gtail + 1) % RD;
                    r.code = RES_QUEUED_GLOBAL;
                end else begin
                    r.code = RES_REJECTED;
                end
            end else if (w >= n) begin
                r.code = RES_BAD_WORKER;
            end else if (req == REQ_FETCH) begin
                if (pop_local(w, r.task_out)) begin
                    r.code = RES_GOT_LOCAL;
                    r.chosen = w;
                end else if (ghead != gtail) begin
                    r.task_out = gring[ghead];
                    ghead = (ghead + 1) % RD;
                    r.code = RES_GOT_GLOBAL;
                end else begin
                    r.code = RES_NONE;
                    if (steal_on) begin
                        for (int i = 0; i < n; i++) begin
                            if (i == w) continue;
                            if (pop_local(i, r.task_out)) begin
                                r.code = RES_STOLEN;
                                r.chosen = i[3:0];
                                break;
                            end
                        end
                    end
                end
            end else begin
                if (done_cnt[w] != 32'hFFFF_FFFF) done_cnt[w]++;
                r.code = RES_COMPLETED;
                r.chosen = w;
            end
            pending.push_back(r);
        endfunction

        // Compares one accepted result with the oldest expectation.
        function void check_result(logic [3:0] code, logic [3:0] chosen, logic [31:0] tout);
            t_result e;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result code=%0d chosen=%0d task=%h", code, chosen, tout);
                return;
            end
            e = pending.pop_front();
            if (e.code !== code || e.chosen !== chosen || e.task_out !== tout) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch exp code=%0d chosen=%0d task=%h got code=%0d chosen=%0d task=%h",
                             e.code, e.chosen, e.task_out, code, chosen, tout);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [39:0] i_s_tdata;   // worker[3:0], task_tag[35:4], preferred_class[37:36], pad
    logic [1:0]  i_s_tuser;   // req_type
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [39:0] o_m_tdata;   // chosen_worker[3:0], task_out[35:4], pad
    logic [3:0]  o_m_tuser;   // result_code
    logic        i_cfg_we;
    logic [1:0]  i_cfg_addr;
    logic [4:0]  i_cfg_wdata;

    dispatch_scoreboard sb;
    int  idle_cycles;
    int  accepted_in;
    bit  hold_off;
    int  n_sub;
    int  n_fetch;
    int  n_steal;

    work_stealing_task_dispatcher #(.NUM_WORKERS(NW), .RING_DEPTH(RD)) dut (.*);

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // Output side: samples at the rising edge, drives ready at the falling edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_result(o_m_tuser, o_m_tdata[3:0], o_m_tdata[35:4]);
            if (o_m_tuser == RES_STOLEN) n_steal++;
        end
        if (i_rst_n && ((o_m_tvalid && i_m_tready) || (i_s_tvalid && o_s_tready)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        int gap;
        i_m_tready = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_m_tready <= 0;
            end else begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
                if ($urandom_range(0, 3) == 0) gap = 0;
                if (gap == 0) begin
                    i_m_tready <= 1;
                end else begin
                    i_m_tready <= 0;
                    repeat (gap - 1) @(negedge i_clk);
                    i_m_tready <= 1;
                end
            end
        end
    end

    // Watchdog on cycles with no accepted transaction.
    always @(posedge i_clk) begin
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offers one request and waits for it to be accepted.
    task automatic send_request(logic [1:0] req, logic [3:0] w, logic [31:0] tg,
                                logic [1:0] pref, bit gaps);
        int gap;
        if (gaps) begin
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
            if ($urandom_range(0, 2) == 0) gap = 0;
            if (gap > 0) begin
                i_s_tvalid <= 0;
                repeat (gap) @(negedge i_clk);
            end
        end
        i_s_tvalid <= 1;
        i_s_tuser <= req;
        i_s_tdata <= {2'b00, pref, tg, w};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_request(req, w, tg, pref);
        accepted_in++;
        if (req == REQ_SUBMIT) n_sub++;
        if (req == REQ_FETCH) n_fetch++;
        @(negedge i_clk);
    endtask

    // Waits until every expected result has come, then lets the block settle.
    task automatic drain();
        i_s_tvalid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [4:0] val);
        i_cfg_we <= 1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        sb.write_reg(idx, val);
    endtask

    // Random request, mostly legal, weighted toward submits and fetches.
    task automatic random_request(int wmax);
        logic [1:0] req;
        logic [3:0] w;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) req = REQ_SUBMIT;
        else if (pick < 85) req = REQ_FETCH;
        else if (pick < 97) req = REQ_COMPLETE;
        else req = REQ_NOP;
        w = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, wmax));
        send_request(req, w, $urandom, 2'($urandom_range(0, 3)), 1);
    endtask

    initial begin
        int hold_len;
        logic [4:0] wc;
        sb = new();
        sb.clear();
        i_rst_n = 0;
        i_s_tvalid = 0;
        i_s_tdata = '0;
        i_s_tuser = REQ_NOP;
        i_cfg_we = 0;
        i_cfg_addr = CFG_WORKER_COUNT;
        i_cfg_wdata = '0;
        hold_off = 0;
        idle_cycles = 0;
        accepted_in = 0;
        n_sub = 0;
        n_fetch = 0;
        n_steal = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed: extremes of fields, every request kind and class.
        send_request(REQ_SUBMIT, 4'd0, 32'h0000_0000, CLS_ANY, 0);
        send_request(REQ_SUBMIT, 4'd15, 32'hFFFF_FFFF, CLS_PERF, 0);
        send_request(REQ_SUBMIT, 4'd7, 32'hA5A5_5A5A, CLS_EFF, 0);
        send_request(REQ_SUBMIT, 4'd0, 32'h1234_5678, 2'd3, 0);
        send_request(REQ_FETCH, 4'd0, 32'hFFFF_FFFF, CLS_ANY, 0);
        send_request(REQ_FETCH, 4'd15, 32'h0, 2'd3, 0);
        send_request(REQ_COMPLETE, 4'd3, 32'h0, CLS_ANY, 0);
        send_request(REQ_NOP, 4'd2, 32'h0, CLS_ANY, 0);
        send_request(REQ_FETCH, 4'd5, 32'h0, CLS_ANY, 0);
        send_request(REQ_FETCH, 4'd6, 32'h0, CLS_ANY, 0);
        send_request(REQ_FETCH, 4'd9, 32'h0, CLS_ANY, 0);
        send_request(REQ_FETCH, 4'd8, 32'h0, CLS_ANY, 0);
        drain();

        // Zero workers, out-of-range requester, stealing disabled.
        write_cfg(CFG_WORKER_COUNT, 5'd0);
        send_request(REQ_SUBMIT, 4'd0, 32'hCAFE_0001, CLS_ANY, 0);
        send_request(REQ_FETCH, 4'd0, 32'h0, CLS_ANY, 0);
        send_request(REQ_COMPLETE, 4'd0, 32'h0, CLS_ANY, 0);
        drain();
        write_cfg(CFG_WORKER_COUNT, 5'd31);
        write_cfg(CFG_PERF_COUNT, 5'd0);
        write_cfg(CFG_STEAL_EN, 5'd0);
        send_request(REQ_SUBMIT, 4'd0, 32'hBEEF_0002, CLS_PERF, 0);
        send_request(REQ_SUBMIT, 4'd0, 32'hBEEF_0003, CLS_EFF, 0);
        send_request(REQ_FETCH, 4'd1, 32'h0, CLS_ANY, 0);
        send_request(REQ_FETCH, 4'd2, 32'h0, CLS_ANY, 0);
        send_request(REQ_FETCH, 4'd4, 32'h0, CLS_ANY, 0);
        drain();

        // Fill rings toward rejection with few workers and no fetches.
        write_cfg(CFG_WORKER_COUNT, 5'd1);
        write_cfg(CFG_PERF_COUNT, 5'd16);
        write_cfg(CFG_STEAL_EN, 5'd1);
        hold_off = 1;
        fork
            begin
                hold_len = 0;
                while (hold_len < 400) begin
                    @(negedge i_clk);
                    hold_len++;
                end
                hold_off = 0;
            end
            repeat (130) send_request(REQ_SUBMIT, 4'($urandom), $urandom, CLS_ANY, 0);
        join
        drain();
        repeat (130) send_request(REQ_FETCH, 4'd0, 32'h0, CLS_ANY, 1);
        drain();

        // Random phases across register settings.
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: wc = 5'd16;
                1: wc = 5'd2;
                2: wc = 5'd1;
                3: wc = 5'd31;
                default: wc = 5'($urandom_range(0, 20));
            endcase
            write_cfg(CFG_WORKER_COUNT, wc);
            write_cfg(CFG_PERF_COUNT, (ph == 3) ? 5'd31 : 5'($urandom_range(0, 17)));
            write_cfg(CFG_STEAL_EN, 5'(ph % 2));
            repeat (175) random_request((wc == 0) ? 0 : ((wc > 16) ? 15 : wc - 1));
            drain();
        end

        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("Covered %0d requests: %0d submits, %0d fetches, %0d steals, %0d results.",
                     accepted_in, n_sub, n_fetch, n_steal, sb.checked);
            $display("Regression PASS");
        end else begin
            $display("Covered %0d requests with %0d mismatches and %0d results outstanding.",
                     accepted_in, sb.mismatches, sb.pending.size());
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
